[rtl/ulsup_pkg.sv]
package ulsup_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_DELAY   = 4'd1,
    PH_FWINFO  = 4'd2,
    PH_FWWAIT  = 4'd3,
    PH_CLOCK   = 4'd4,
    PH_CLKWAIT = 4'd5,
    PH_NORMAL  = 4'd6,
    PH_RECWAIT = 4'd7,
    PH_LOGWAIT = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    SK_NONE    = 3'd0,
    SK_FWINFO  = 3'd1,
    SK_CLOCK   = 3'd2,
    SK_DEVINFO = 3'd3,
    SK_TAX     = 3'd4,
    SK_METER   = 3'd5,
    SK_LOG     = 3'd6
  } send_e;

  typedef enum logic [1:0] {
    VD_ACCEPT  = 2'd0,
    VD_CRC_BAD = 2'd1,
    VD_SEQ_BAD = 2'd2,
    VD_TICK    = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    RL_NONE    = 2'd0,
    RL_DEVINFO = 2'd1,
    RL_TAX     = 2'd2,
    RL_METER   = 2'd3
  } release_e;

  // reply kinds
  localparam logic [2:0] RK_FWINFO  = 3'd0;
  localparam logic [2:0] RK_CLOCK   = 3'd1;
  localparam logic [2:0] RK_LOG     = 3'd3;
  localparam logic [2:0] RK_DEVINFO = 3'd4;
  localparam logic [2:0] RK_TAX     = 3'd5;
  localparam logic [2:0] RK_METER   = 3'd6;

  localparam logic OP_REPLY = 1'b1;

  localparam logic [1:0] BM_GUN   = 2'd1;
  localparam logic [1:0] BM_METER = 2'd2;

  // configuration register map
  localparam int unsigned AddrW = 5;
  localparam int unsigned NumRegs = 8;
  localparam logic [2:0] REG_START_DELAY = 3'd0;
  localparam logic [2:0] REG_FW_TIMEOUT  = 3'd1;
  localparam logic [2:0] REG_FW_RETRY    = 3'd2;
  localparam logic [2:0] REG_CLK_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_CLK_RETRY   = 3'd4;
  localparam logic [2:0] REG_REC_TIMEOUT = 3'd5;
  localparam logic [2:0] REG_LOG_TIMEOUT = 3'd6;
  localparam logic [2:0] REG_NORM_RETRY  = 3'd7;

  localparam logic [7:0] RST_START_DELAY = 8'd6;
  localparam logic [7:0] RST_FW_TIMEOUT  = 8'd6;
  localparam logic [7:0] RST_FW_RETRY    = 8'd5;
  localparam logic [7:0] RST_CLK_TIMEOUT = 8'd30;
  localparam logic [7:0] RST_CLK_RETRY   = 8'd3;
  localparam logic [7:0] RST_REC_TIMEOUT = 8'd30;
  localparam logic [7:0] RST_LOG_TIMEOUT = 8'd15;
  localparam logic [7:0] RST_NORM_RETRY  = 8'd3;

  typedef struct packed {
    logic [7:0] start_delay_ticks;
    logic [7:0] fw_info_timeout;
    logic [7:0] fw_info_retry_limit;
    logic [7:0] clock_timeout;
    logic [7:0] clock_retry_limit;
    logic [7:0] record_timeout;
    logic [7:0] log_timeout;
    logic [7:0] normal_retry_limit;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic        network_ready;
    logic        devinfo_pending;
    logic        tax_record_pending;
    logic        meter_record_pending;
    logic        log_due;
    logic        time_sync_due;
    logic [2:0]  reply_kind;
    logic        reply_flag;
    logic [31:0] reply_seq;
    logic        crc_ok;
    logic [1:0]  board_mode;
  } item_t;

  typedef struct packed {
    send_e       send_kind;
    logic [31:0] send_seq;
    logic        link_reset;
    verdict_e    verdict;
    logic        set_clock;
    release_e    release_kind;
    logic [31:0] upload_count;
    phase_e      fsm_state;
    logic        last;
  } result_t;

endpackage

[rtl/ulsup_cfg.sv]
module ulsup_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ulsup_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ulsup_pkg::cfg_t             cfg_o
);
  import ulsup_pkg::*;

  logic [7:0] regs_q [NumRegs];
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign prdata = {24'd0, regs_q[idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[REG_START_DELAY] <= RST_START_DELAY;
      regs_q[REG_FW_TIMEOUT]  <= RST_FW_TIMEOUT;
      regs_q[REG_FW_RETRY]    <= RST_FW_RETRY;
      regs_q[REG_CLK_TIMEOUT] <= RST_CLK_TIMEOUT;
      regs_q[REG_CLK_RETRY]   <= RST_CLK_RETRY;
      regs_q[REG_REC_TIMEOUT] <= RST_REC_TIMEOUT;
      regs_q[REG_LOG_TIMEOUT] <= RST_LOG_TIMEOUT;
      regs_q[REG_NORM_RETRY]  <= RST_NORM_RETRY;
    end else if (wr_en) begin
      regs_q[idx] <= pwdata[7:0];
    end
  end

  always_comb begin
    cfg_o.start_delay_ticks   = regs_q[REG_START_DELAY];
    cfg_o.fw_info_timeout     = regs_q[REG_FW_TIMEOUT];
    cfg_o.fw_info_retry_limit = regs_q[REG_FW_RETRY];
    cfg_o.clock_timeout       = regs_q[REG_CLK_TIMEOUT];
    cfg_o.clock_retry_limit   = regs_q[REG_CLK_RETRY];
    cfg_o.record_timeout      = regs_q[REG_REC_TIMEOUT];
    cfg_o.log_timeout         = regs_q[REG_LOG_TIMEOUT];
    cfg_o.normal_retry_limit  = regs_q[REG_NORM_RETRY];
  end

endmodule

[rtl/ulsup_core.sv]
module ulsup_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ulsup_pkg::item_t   item_i,
  input  ulsup_pkg::cfg_t    cfg_i,
  output ulsup_pkg::result_t res0_o,
  output ulsup_pkg::result_t res1_o,
  output logic               two_o
);
  import ulsup_pkg::*;

  typedef struct packed {
    logic [7:0] wait_count;
    logic [7:0] retry_count;
    logic       expired;
    logic       give_up;
  } wait_t;

  function automatic wait_t wait_step(logic [7:0] wc, logic [7:0] rc,
                                      logic [7:0] timeout, logic [7:0] limit);
    wait_t      w;
    logic [7:0] wc1;
    logic [7:0] rc1;
    wc1 = (wc == 8'hFF) ? wc : wc + 8'd1;
    rc1 = (rc == 8'hFF) ? rc : rc + 8'd1;
    w.expired = (wc1 >= timeout);
    w.give_up = w.expired && (rc1 >= limit);
    w.wait_count  = w.expired ? 8'd0 : wc1;
    w.retry_count = w.expired ? rc1 : rc;
    return w;
  endfunction

  phase_e      phase_q, phase_d;
  logic [7:0]  delay_q, delay_d;
  logic [7:0]  wait_q, wait_d;
  logic [7:0]  retry_q, retry_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] acked_q, acked_d;

  send_e       send_a, send_b;
  logic        link_rst;
  verdict_e    verdict;
  logic        set_clk;
  release_e    rel;
  wait_t       ws;
  logic [7:0]  dly_inc;

  // next state
  always_comb begin
    phase_d  = phase_q;
    delay_d  = delay_q;
    wait_d   = wait_q;
    retry_d  = retry_q;
    acked_d  = acked_q;
    send_a   = SK_NONE;
    send_b   = SK_NONE;
    link_rst = 1'b0;
    verdict  = VD_TICK;
    set_clk  = 1'b0;
    rel      = RL_NONE;
    ws       = '0;
    dly_inc  = delay_q + 8'd1;

    if (item_i.opcode == OP_REPLY) begin
      if (!item_i.crc_ok) begin
        verdict = VD_CRC_BAD;
      end else if (item_i.reply_flag && (item_i.reply_seq + 32'd1) != seq_q) begin
        verdict = VD_SEQ_BAD;
      end else begin
        verdict = VD_ACCEPT;
        case (item_i.reply_kind)
          RK_FWINFO: begin
            if (phase_q == PH_FWWAIT) begin
              phase_d = PH_CLOCK;
              delay_d = '0; wait_d = '0; retry_d = '0;
            end
          end
          RK_CLOCK: begin
            set_clk = 1'b1;
            if (phase_q == PH_CLKWAIT) begin
              phase_d = PH_NORMAL;
              delay_d = '0; wait_d = '0; retry_d = '0;
            end
          end
          RK_LOG: begin
            if (phase_q == PH_LOGWAIT) begin
              phase_d = PH_NORMAL;
              delay_d = '0; wait_d = '0; retry_d = '0;
            end
          end
          RK_DEVINFO, RK_TAX, RK_METER: begin
            rel = release_e'(2'(item_i.reply_kind - RK_LOG));
            if ((item_i.reply_kind == RK_TAX && item_i.board_mode == BM_GUN) ||
                (item_i.reply_kind == RK_METER && item_i.board_mode == BM_METER)) begin
              acked_d = acked_q + 32'd1;
            end
            if (phase_q == PH_RECWAIT) begin
              phase_d = PH_NORMAL;
              delay_d = '0; wait_d = '0; retry_d = '0;
            end
          end
          default: ;
        endcase
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (item_i.network_ready) begin
            phase_d = PH_DELAY;
            delay_d = '0; wait_d = '0; retry_d = '0;
          end
        end
        PH_DELAY: begin
          delay_d = dly_inc;
          if (dly_inc == cfg_i.start_delay_ticks) begin
            phase_d = PH_FWINFO;
            delay_d = '0;
          end
        end
        PH_FWINFO: begin
          send_a  = SK_FWINFO;
          phase_d = PH_FWWAIT;
        end
        PH_FWWAIT: begin
          ws = wait_step(wait_q, retry_q, cfg_i.fw_info_timeout, cfg_i.fw_info_retry_limit);
          wait_d  = ws.wait_count;
          retry_d = ws.retry_count;
          if (ws.expired) phase_d = ws.give_up ? PH_IDLE : PH_FWINFO;
          link_rst = ws.give_up;
        end
        PH_CLOCK: begin
          send_a  = SK_CLOCK;
          phase_d = PH_CLKWAIT;
          wait_d  = '0;
        end
        PH_CLKWAIT: begin
          ws = wait_step(wait_q, retry_q, cfg_i.clock_timeout, cfg_i.clock_retry_limit);
          wait_d  = ws.wait_count;
          retry_d = ws.retry_count;
          if (ws.expired) phase_d = ws.give_up ? PH_IDLE : PH_CLOCK;
          link_rst = ws.give_up;
        end
        PH_NORMAL: begin
          if (item_i.devinfo_pending) send_a = SK_DEVINFO;
          else if (item_i.tax_record_pending) send_a = SK_TAX;
          else if (item_i.meter_record_pending) send_a = SK_METER;
          if (send_a != SK_NONE) begin
            phase_d = PH_RECWAIT;
            wait_d  = '0;
          end
          if (item_i.log_due) begin
            // a resync request takes the slot instead of the log
            if (item_i.time_sync_due) begin
              phase_d = PH_CLOCK;
              delay_d = '0; wait_d = '0; retry_d = '0;
            end else begin
              send_b  = SK_LOG;
              phase_d = PH_LOGWAIT;
              wait_d  = '0;
            end
          end
        end
        PH_RECWAIT: begin
          ws = wait_step(wait_q, retry_q, cfg_i.record_timeout, cfg_i.normal_retry_limit);
          wait_d  = ws.wait_count;
          retry_d = ws.retry_count;
          if (ws.expired) phase_d = ws.give_up ? PH_IDLE : PH_NORMAL;
          link_rst = ws.give_up;
        end
        PH_LOGWAIT: begin
          ws = wait_step(wait_q, retry_q, cfg_i.log_timeout, cfg_i.normal_retry_limit);
          wait_d  = ws.wait_count;
          retry_d = ws.retry_count;
          if (ws.expired) phase_d = ws.give_up ? PH_IDLE : PH_NORMAL;
          link_rst = ws.give_up;
        end
        default: phase_d = PH_IDLE;
      endcase
    end

    seq_d = seq_q + 32'(send_a != SK_NONE) + 32'(send_b != SK_NONE);
  end

  // result items
  always_comb begin
    res0_o = '0;
    res0_o.verdict      = verdict;
    res0_o.set_clock    = set_clk;
    res0_o.release_kind = rel;
    res0_o.upload_count = acked_d;
    res0_o.fsm_state    = phase_d;
    res0_o.last         = 1'b1;
    res0_o.link_reset   = link_rst;
    res1_o = res0_o;
    two_o  = 1'b0;
    if (send_a != SK_NONE) begin
      res0_o.send_kind = send_a;
      res0_o.send_seq  = seq_q;
      if (send_b != SK_NONE) begin
        two_o            = 1'b1;
        res0_o.last      = 1'b0;
        res1_o.send_kind = send_b;
        res1_o.send_seq  = seq_q + 32'd1;
      end
    end else if (send_b != SK_NONE) begin
      res0_o.send_kind = send_b;
      res0_o.send_seq  = seq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      delay_q <= '0;
      wait_q  <= '0;
      retry_q <= '0;
      seq_q   <= '0;
      acked_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      delay_q <= delay_d;
      wait_q  <= wait_d;
      retry_q <= retry_d;
      seq_q   <= seq_d;
      acked_q <= acked_d;
    end
  end

  a_reply_keeps_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.opcode == OP_REPLY |=> seq_q == $past(seq_q))
    else $error("sequence number moved on a reply");

  a_tick_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.opcode != OP_REPLY |=> acked_q == $past(acked_q))
    else $error("upload count moved on a tick");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    two_o |-> !res0_o.last && res1_o.last && res0_o.send_kind != SK_NONE &&
              res1_o.send_kind == SK_LOG)
    else $error("bad record and log pair");

  a_reset_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res0_o.link_reset |-> res0_o.fsm_state == PH_IDLE && res0_o.send_kind == SK_NONE)
    else $error("link reset without return to idle");

endmodule

[rtl/ulsup_obuf.sv]
module ulsup_obuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               two_i,
  input  ulsup_pkg::result_t res0_i,
  input  ulsup_pkg::result_t res1_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ulsup_pkg::result_t res_o
);
  import ulsup_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] tail_nx;
  logic            pop;

  // room for two results keeps one transfer a cycle going while results drain
  assign space_o     = cnt_q <= CntW'(Depth - 2);
  assign out_valid_o = cnt_q != '0;
  assign res_o       = mem_q[head_q];
  assign pop         = out_valid_o & out_ready_i;
  assign tail_nx     = tail_q + PtrW'(1);

  always_comb begin
    head_d = pop ? head_q + PtrW'(1) : head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q - CntW'(pop);
    if (push_i) begin
      tail_d = two_i ? tail_q + PtrW'(2) : tail_nx;
      cnt_d  = cnt_d + (two_i ? CntW'(2) : CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= res0_i;
      if (two_i) mem_q[tail_nx] <= res1_i;
    end
  end

endmodule

[rtl/upload_link_supervisor.sv]
// upload link supervisor
// input channel: in_valid_i/in_ready_o carry one item, either a scheduler
// tick (opcode 0) or a received reply (opcode 1). a transfer updates the
// link state machine, sequence counter and upload counter in the same cycle.
// output channel: out_valid_o/out_ready_i carry result items. a reply gives
// one result, a tick gives one, or two when a record and a log are sent
// together; last_o marks the final result of an item.
// a result is written into the result queue when its item is taken.
// throughput: one item per cycle while each gives one result and the
// receiver takes results; an item with two results drains them one at a
// time through the single output port of the four-entry result queue.
// in_ready_o stays high while the queue has room for two results, so the
// block keeps taking items while a result waits; a stalled receiver fills
// the queue and then holds off the input side.
// reset: registers go to their default values, the link is idle and the
// sequence and upload counters are zero.
// configuration: APB writes at byte address 4*index; the user must make
// them only while no item or result is in flight; block does not enforce it.
module upload_link_supervisor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ulsup_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic                        network_ready_i,
  input  logic                        devinfo_pending_i,
  input  logic                        tax_record_pending_i,
  input  logic                        meter_record_pending_i,
  input  logic                        log_due_i,
  input  logic                        time_sync_due_i,
  input  logic [2:0]                  reply_kind_i,
  input  logic                        reply_flag_i,
  input  logic [31:0]                 reply_seq_i,
  input  logic                        crc_ok_i,
  input  logic [1:0]                  board_mode_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  send_kind_o,
  output logic [31:0]                 send_seq_o,
  output logic                        link_reset_o,
  output logic [1:0]                  verdict_o,
  output logic                        set_clock_o,
  output logic [1:0]                  release_kind_o,
  output logic [31:0]                 upload_count_o,
  output logic [3:0]                  fsm_state_o,
  output logic                        last_o
);
  import ulsup_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res0, res1, res;
  logic    two;
  logic    accept;

  assign accept = in_valid_i & in_ready_o;

  always_comb begin
    item.opcode               = opcode_i;
    item.network_ready        = network_ready_i;
    item.devinfo_pending      = devinfo_pending_i;
    item.tax_record_pending   = tax_record_pending_i;
    item.meter_record_pending = meter_record_pending_i;
    item.log_due              = log_due_i;
    item.time_sync_due        = time_sync_due_i;
    item.reply_kind           = reply_kind_i;
    item.reply_flag           = reply_flag_i;
    item.reply_seq            = reply_seq_i;
    item.crc_ok               = crc_ok_i;
    item.board_mode           = board_mode_i;
  end

  ulsup_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ulsup_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg),
    .res0_o   (res0),
    .res1_o   (res1),
    .two_o    (two)
  );

  ulsup_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .two_i       (two),
    .res0_i      (res0),
    .res1_i      (res1),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign send_kind_o    = res.send_kind;
  assign send_seq_o     = res.send_seq;
  assign link_reset_o   = res.link_reset;
  assign verdict_o      = res.verdict;
  assign set_clock_o    = res.set_clock;
  assign release_kind_o = res.release_kind;
  assign upload_count_o = res.upload_count;
  assign fsm_state_o    = res.fsm_state;
  assign last_o         = res.last;

endmodule
